### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of the receive queue.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ULRQ_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ULRQ_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

### rtl/core/ulrq_pkg.sv
// Shared types, constants and helpers of the UART line receive queue.
// Depends on nothing.
`timescale 1ns / 1ps

package ulrq_pkg;

	// Sizing
	localparam int LINE_BYTES  = 128;
	localparam int QUEUE_LINES = 4;
	// One spare slot always holds the line under assembly
	localparam int SLOTS       = QUEUE_LINES + 1;

	localparam int LEN_W   = $clog2(LINE_BYTES);
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(QUEUE_LINES + 1);
	localparam int DEPTH   = SLOTS * LINE_BYTES;
	localparam int ADDR_W  = $clog2(DEPTH);

	// Port field widths
	localparam int FUNC_W  = 2;
	localparam int BYTE_W  = 8;
	localparam int INDEX_W = 7;
	localparam int HLEN_W  = 7;
	localparam int QCNT_W  = 3;
	localparam int CMP_W   = (LEN_W > INDEX_W) ? LEN_W : INDEX_W;

	localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_RX_BYTE  = 2'd0,
		FUNC_READ     = 2'd1,
		FUNC_RELEASE  = 2'd2,
		FUNC_TAKE_ERR = 2'd3
	} func_t;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// Advance a slot pointer around the ring
	function automatic slot_t slot_next(input slot_t s);
		slot_t r;
		if (s == SLOT_W'(SLOTS - 1)) begin
			r = '0;
		end else begin
			r = s + 1'b1;
		end
		return r;
	endfunction

	// Byte address of one position in one slot
	function automatic addr_t slot_addr(input slot_t s, input len_t pos);
		addr_t r;
		r = ADDR_W'(s) * ADDR_W'(LINE_BYTES) + ADDR_W'(pos);
		return r;
	endfunction

endpackage

### rtl/core/uart_line_receive_queue_core.sv
// Top level of the UART line receive queue: control, slot ring and output register.
// Depends on ulrq_pkg and ulrq_line_ram.
`timescale 1ns / 1ps

//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | func, rx_byte, read_index
//  out     | output    | out_valid/out_stall | read_data, head_length, lines_queued,
//          |           |                     | error_flag, released
//
// Each beat is handled in order: the accept cycle updates the state and issues the
// line store read, and the output register is then loaded from the read data once it is free.
// Lines are assembled in place in a spare slot of the line store, so finishing a
// line only hands the slot over; no copy is made.
// Reset clears all control state at once; the line store needs no clearing pass.
// The input stalls while a beat is in flight or the output register is held.
module uart_line_receive_queue_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [ulrq_pkg::FUNC_W-1:0]     func,
	input  logic [ulrq_pkg::BYTE_W-1:0]     rx_byte,
	input  logic [ulrq_pkg::INDEX_W-1:0]    read_index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ulrq_pkg::BYTE_W-1:0]     read_data,
	output logic [ulrq_pkg::HLEN_W-1:0]     head_length,
	output logic [ulrq_pkg::QCNT_W-1:0]     lines_queued,
	output logic                            error_flag,
	output logic                            released
);

	import ulrq_pkg::*;

	// Control state
	len_t  asm_len_q;
	logic  ovf_q;
	len_t  slot_len_q [SLOTS];
	slot_t head_q;
	slot_t tail_q;
	cnt_t  count_q;
	logic  pend_q;

	// Next state
	len_t  asm_len_d;
	logic  ovf_d;
	logic  commit;
	slot_t head_d;
	slot_t tail_d;
	cnt_t  count_d;
	logic  pend_d;

	// Stage one: beat in flight
	logic  valid_s1;
	logic  hit_s1;
	logic  err_s1;
	logic  rel_s1;

	logic  accept;
	logic  load_out;
	logic  hit;
	logic  err;
	logic  rel;

	// Line store ports
	logic               wr_en;
	addr_t              wr_addr;
	logic [BYTE_W-1:0]  wr_data;
	addr_t              rd_addr;
	logic [BYTE_W-1:0]  rd_data;

	// Output register
	logic               out_valid_q;
	logic [BYTE_W-1:0]  read_data_q;
	logic [HLEN_W-1:0]  head_length_q;
	logic [QCNT_W-1:0]  lines_queued_q;
	logic               error_flag_q;
	logic               released_q;

	assign in_stall = valid_s1 | (out_valid_q & out_stall);
	assign accept   = in_valid & ~in_stall;
	assign load_out = valid_s1 & (~out_valid_q | ~out_stall);

	// Decode the beat and work out the next state
	always_comb begin
		asm_len_d = asm_len_q;
		ovf_d     = ovf_q;
		commit    = 1'b0;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		pend_d    = pend_q;
		hit       = 1'b0;
		rel       = 1'b0;
		err       = pend_q;
		wr_en     = 1'b0;
		wr_addr   = slot_addr(tail_q, asm_len_q);
		wr_data   = rx_byte;
		rd_addr   = slot_addr(head_q, LEN_W'(read_index));
		case (func_t'(func))
			FUNC_RX_BYTE: begin
				if (rx_byte == BYTE_CR) begin
					// ignore carriage return
				end else if (rx_byte == BYTE_LF) begin
					if (ovf_q) begin
						pend_d = 1'b1;
					end else if (asm_len_q != '0) begin
						if (count_q == CNT_W'(QUEUE_LINES)) begin
							pend_d = 1'b1;
						end else begin
							commit  = 1'b1;
							tail_d  = slot_next(tail_q);
							count_d = count_q + 1'b1;
						end
					end
					asm_len_d = '0;
					ovf_d     = 1'b0;
				end else if (!ovf_q) begin
					if (asm_len_q < LEN_W'(LINE_BYTES - 1)) begin
						wr_en     = 1'b1;
						asm_len_d = asm_len_q + 1'b1;
					end else begin
						ovf_d     = 1'b1;
						asm_len_d = '0;
					end
				end
				err = pend_d;
			end
			FUNC_READ: begin
				hit = (count_q != '0) &&
					(CMP_W'(read_index) < CMP_W'(slot_len_q[head_q]));
			end
			FUNC_RELEASE: begin
				if (count_q != '0) begin
					head_d  = slot_next(head_q);
					count_d = count_q - 1'b1;
					rel     = 1'b1;
				end
			end
			FUNC_TAKE_ERR: begin
				pend_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Commit state on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asm_len_q <= '0;
			ovf_q     <= 1'b0;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			pend_q    <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_len_q[i] <= '0;
			end
		end else if (accept) begin
			asm_len_q <= asm_len_d;
			ovf_q     <= ovf_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			count_q   <= count_d;
			pend_q    <= pend_d;
			if (commit) begin
				slot_len_q[tail_q] <= asm_len_q;
			end
		end
	end

	ulrq_line_ram #(
		.WIDTH  (BYTE_W),
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (accept & wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Track the beat in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load_out) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1 <= hit;
			err_s1 <= err;
			rel_s1 <= rel;
		end
	end

	// Output valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result beat from the updated state and the read data
	always_ff @(posedge clk) begin
		if (load_out) begin
			read_data_q    <= hit_s1 ? rd_data : '0;
			head_length_q  <= (count_q != '0) ? HLEN_W'(slot_len_q[head_q]) : '0;
			lines_queued_q <= QCNT_W'(count_q);
			error_flag_q   <= err_s1;
			released_q     <= rel_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = read_data_q;
	assign head_length  = head_length_q;
	assign lines_queued = lines_queued_q;
	assign error_flag   = error_flag_q;
	assign released     = released_q;

endmodule

### rtl/core/ulrq_line_ram.sv
// Simple dual-port line store: one write port, one registered read port.
// Depends on nothing; sized by its parameters.
`timescale 1ns / 1ps

module ulrq_line_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 640,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write one byte
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read when enabled, hold otherwise
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/ulrq_checker.sv
// Port-level checks of the UART line receive queue, bound to the top level.
// Depends on ulrq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ulrq_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic [ulrq_pkg::FUNC_W-1:0]     func,
	input logic [ulrq_pkg::BYTE_W-1:0]     rx_byte,
	input logic [ulrq_pkg::INDEX_W-1:0]    read_index,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [ulrq_pkg::BYTE_W-1:0]     read_data,
	input logic [ulrq_pkg::HLEN_W-1:0]     head_length,
	input logic [ulrq_pkg::QCNT_W-1:0]     lines_queued,
	input logic                            error_flag,
	input logic                            released
);

	import ulrq_pkg::*;

	logic in_beat;
	logic unused_ok;

	assign in_beat   = in_valid & ~in_stall;
	assign unused_ok = ^{func, rx_byte, read_index, error_flag, released};

	// One beat at a time: the input stalls right after an accept
	`ULRQ_ASSERT(a_one_in_flight, clk, arst_n, in_beat |=> in_stall, "beat accepted while busy")

	// Queue never holds more than its line count
	`ULRQ_NEVER(a_count_range, clk, arst_n,
		out_valid && (lines_queued > QCNT_W'(QUEUE_LINES)), "lines_queued out of range")

	// Empty queue reports no head line and no data
	`ULRQ_ASSERT(a_empty_head, clk, arst_n,
		(out_valid && lines_queued == '0) |-> (head_length == '0 && read_data == '0),
		"empty queue shows head data")

	// A held result stays offered
	`ULRQ_ASSERT(a_out_hold, clk, arst_n, (out_valid && out_stall) |=> out_valid,
		"result dropped while stalled")

endmodule

bind uart_line_receive_queue_core ulrq_checker u_ulrq_checker (.*);
